FILE: rtl/spvg_pkg.sv
// ----------------------------------------------------------------------------
// Star polygon vertex generator package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package spvg_pkg;

   localparam int COORD_W = 24;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic [5:0]                vertex_index;
      logic                      last_vertex;
   } rsp_type;

   localparam logic csr_index_vertex_count = 1'b0;
   localparam logic csr_index_inner_ratio  = 1'b1;

   localparam int CSR_W = 7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ANGLE, ST_DIV, ST_ITER, ST_GX, ST_GY,
      ST_RX, ST_RY, ST_DX, ST_DY, ST_OUT
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: rtl/spvg_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 40 by 7 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spvg_divider
   import spvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] dividend,
   input  logic [6:0]  divisor,
   output logic        done,
   output logic [39:0] quotient
);

   logic [5:0]  count_ff, count_in;
   logic [39:0] quot_ff, quot_in;
   logic [7:0]  rem_ff, rem_in;
   logic        busy_ff, busy_in;
   logic [7:0]  trial;

   always_comb begin
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff[6:0], quot_ff[39]};
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         count_in = 6'd40;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in  = trial - {1'b0, divisor};
            quot_in = {quot_ff[38:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[38:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done     = busy_ff && (count_ff == 6'd1);
   assign quotient = {quot_ff[38:0], (trial >= {1'b0, divisor})};

endmodule

FILE: rtl/star_polygon_vertex_generator.sv
// ----------------------------------------------------------------------------
// Star polygon vertex generator
// Emits the 2N vertices of a star from a center point and a drag point.
// ----------------------------------------------------------------------------
// One request carries a center and a drag point. The block emits 2N vertex
// responses in polygon order, even ones on the outer radius and odd ones on
// the inner radius, and flags the last one. Each vertex is found by rotating
// the offset vector with one shared CORDIC stage run CORDIC_STEPS times (at most 24). The
// step angle k/(2N) of a turn comes from a serial divider. The gain is removed
// with one shared multiplier, and the division by 100 for the inner radius is
// a reciprocal multiplication split over two steps. The request channel is
// not ready while a star is being produced; a finished vertex waits in the
// response register, and the next vertex does not start its angle division
// until that register is free.
module star_polygon_vertex_generator
   import spvg_pkg::*;
#(
   parameter int MAX_POINTS      = 32,
   parameter int COORD_FRAC_BITS = 8,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   // Coordinates are plain integers; the fraction bits do not change the math.
   localparam int STEP_W = (CORDIC_STEPS > 24) ? 5 : $clog2(CORDIC_STEPS + 1);
   localparam int VW = 42; // guard-scaled vector plus CORDIC growth

   // Division by 100 as two reciprocal multiplications: the upper 20 bits of
   // the numerator first, then their remainder joined with the lower 20 bits.
   localparam logic [20:0] RECIP_HI = 21'd1342178;   // ceil(2^27 / 100)
   localparam logic [27:0] RECIP_LO = 28'd171798692; // ceil(2^34 / 100)

   state_type state_ff, state_in;

   logic [5:0] count_ff;
   logic [6:0] ratio_ff;

   logic signed [24:0] cx_ff, cy_ff;
   logic signed [VW-1:0] x_ff, x_in, y_ff, y_in, bx_ff, by_ff;
   logic signed [32:0] z_ff, z_in;
   logic [STEP_W-1:0] it_ff, it_in;
   logic [5:0] k_ff, k_in;
   logic [6:0] tot_ff;
   logic [5:0] n_eff;
   logic [6:0] r_eff;
   logic signed [VW-1:0] ox_ff, ox_in, oy_ff, oy_in;
   rsp_type out_ff, out_in;
   logic out_v_ff, out_v_in;

   logic [39:0] num_ff, num_in;
   logic [13:0] qh_ff, qh_in;
   logic [26:0] rl_ff, rl_in;
   logic [40:0] hi_p;
   logic [13:0] hi_q;
   logic [20:0] hi_m;
   logic [6:0]  hi_r;
   logic [54:0] lo_p;
   logic [19:0] lo_q;
   logic [39:0] q100;

   // Divider for the angle step.
   logic        dv_start, dv_done;
   logic [39:0] dv_num, dv_q;
   logic [6:0]  dv_den;

   spvg_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_num),
      .divisor(dv_den), .done(dv_done), .quotient(dv_q)
   );

   // Shared multiplier: a vector value times the 24 bit gain constant.
   logic signed [VW-1:0]  mul_a;
   logic signed [24:0]    mul_b;
   logic signed [VW+24:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic signed [VW+24:0] rmag;
   logic signed [VW-1:0]  rnd_res;
   logic signed [VW-1:0]  xs, ys, sx, sy;
   logic [31:0]           ang;
   logic                  zpos;

   assign n_eff = (count_ff < 6'd3) ? 6'd3 :
                  (count_ff > 6'(MAX_POINTS)) ? 6'(MAX_POINTS) : count_ff;
   assign r_eff = (ratio_ff > 7'd100) ? 7'd100 : ratio_ff;

   // Round the multiplier product divided by 2^24, halves away from zero.
   always_comb begin
      rmag    = mul_p[VW+24] ? -mul_p : mul_p;
      rmag    = (rmag + (1 <<< 23)) >>> 24;
      rnd_res = mul_p[VW+24] ? -rmag[VW-1:0] : rmag[VW-1:0];
   end

   assign xs   = x_ff >>> it_ff;
   assign ys   = y_ff >>> it_ff;
   assign zpos = !z_ff[32];
   assign ang  = dv_q[31:0];

   // Upper step: quotient and remainder of the top 20 numerator bits.
   assign hi_p = num_ff[39:20] * RECIP_HI;
   assign hi_q = hi_p[40:27];
   assign hi_m = hi_q * 7'd100;
   assign hi_r = 7'(num_ff[39:20] - hi_m[19:0]);
   // Lower step: the remainder with the low 20 bits is below 100 * 2^20.
   assign lo_p = rl_ff * RECIP_LO;
   assign lo_q = lo_p[53:34];
   assign q100 = {6'b0, qh_ff, lo_q};

   function automatic logic signed [VW-1:0] rnd_div(input logic signed [VW-1:0] v,
                                                     input logic [39:0] q);
      logic signed [VW-1:0] r;
      begin
         r = v[VW-1] ? -$signed({2'b00, q}) : $signed({2'b00, q});
         return r;
      end
   endfunction

   function automatic logic signed [COORD_W-1:0] sat(input logic signed [VW:0] v);
      logic signed [COORD_W-1:0] r;
      begin
         if (v > 43'sd8388607) r = 24'sh7FFFFF;
         else if (v < -43'sd8388608) r = 24'sh800000;
         else r = v[COORD_W-1:0];
         return r;
      end
   endfunction

   logic signed [VW-1:0] gmag;
   assign gmag = ox_ff[VW-1] ? -ox_ff : ox_ff;
   logic signed [VW-1:0] gmag_y;
   assign gmag_y = oy_ff[VW-1] ? -oy_ff : oy_ff;
   logic signed [VW-1:0] gx_r, gy_r;
   assign gx_r = ox_ff[VW-1] ? -((gmag + 42'sd128) >>> 8) : ((gmag + 42'sd128) >>> 8);
   assign gy_r = oy_ff[VW-1] ? -((gmag_y + 42'sd128) >>> 8) : ((gmag_y + 42'sd128) >>> 8);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_ANGLE;
         ST_ANGLE: if (!out_v_ff || rsp_ready) state_in = ST_DIV;
         ST_DIV: if (dv_done) state_in = ST_ITER;
         ST_ITER: if (it_ff == STEP_W'(CORDIC_STEPS > 24 ? 24 : CORDIC_STEPS) - 1'b1)
            state_in = ST_GX;
         ST_GX: state_in = ST_GY;
         ST_GY: state_in = k_ff[0] ? ST_RX : ST_OUT;
         ST_RX: state_in = ST_DX;
         ST_DX: state_in = ST_RY;
         ST_RY: state_in = ST_DY;
         ST_DY: state_in = ST_OUT;
         ST_OUT: if (!out_v_ff || rsp_ready)
            state_in = ({1'b0, k_ff} == tot_ff - 7'd1) ? ST_IDLE : ST_ANGLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; it_in = it_ff; k_in = k_ff;
      ox_in = ox_ff; oy_in = oy_ff; out_in = out_ff;
      num_in = num_ff; qh_in = qh_ff; rl_in = rl_ff;
      out_v_in = out_v_ff && !rsp_ready;
      dv_start = 1'b0; dv_num = '0; dv_den = {n_eff, 1'b0};
      mul_a = '0; mul_b = '0;
      req_ready = (state_ff == ST_IDLE);
      sx = '0; sy = '0;
      case (state_ff)
         ST_IDLE: if (req_valid) k_in = '0;
         ST_ANGLE: begin
            // (k*2^32 + N) / 2N
            dv_start = 1'b1;
            dv_num   = {2'b00, k_ff, 32'h0} + 40'(n_eff);
         end
         ST_DIV: begin
            if (dv_done) begin
               if (ang[31] ^ ang[30]) begin
                  x_in = -bx_ff; y_in = -by_ff;
                  z_in = $signed({ang[31] ^ 1'b1, ang[31] ^ 1'b1, ang[30:0]});
               end else begin
                  x_in = bx_ff; y_in = by_ff;
                  z_in = $signed({ang[31], ang});
               end
               it_in = '0;
            end
         end
         ST_ITER: begin
            if (zpos) begin
               x_in = x_ff - ys; y_in = y_ff + xs;
               z_in = z_ff - $signed({1'b0, atan_entry(5'(it_ff))});
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs;
               z_in = z_ff + $signed({1'b0, atan_entry(5'(it_ff))});
            end
            it_in = it_ff + 1'b1;
         end
         ST_GX: begin
            mul_a = x_ff; mul_b = 25'sd10188014; ox_in = rnd_res;
         end
         ST_GY: begin
            mul_a = y_ff; mul_b = 25'sd10188014; oy_in = rnd_res;
         end
         ST_RX: begin
            // |ox|*ratio with half of 100 added for rounding.
            sx = ox_ff[VW-1] ? -ox_ff : ox_ff;
            num_in = 40'(sx * $signed({1'b0, r_eff})) + 40'd50;
         end
         ST_DX: begin
            qh_in = hi_q;
            rl_in = {hi_r, num_ff[19:0]};
            sy = oy_ff[VW-1] ? -oy_ff : oy_ff;
            num_in = 40'(sy * $signed({1'b0, r_eff})) + 40'd50;
         end
         ST_RY: begin
            ox_in = rnd_div(ox_ff, q100);
            qh_in = hi_q;
            rl_in = {hi_r, num_ff[19:0]};
         end
         ST_DY: oy_in = rnd_div(oy_ff, q100);
         ST_OUT: begin
            if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1;
               out_in.vertex_x = sat(43'(cx_ff) + 43'(gx_r));
               out_in.vertex_y = sat(43'(cy_ff) + 43'(gy_r));
               out_in.vertex_index = k_ff;
               out_in.last_vertex = ({1'b0, k_ff} == tot_ff - 7'd1);
               k_in = k_ff + 6'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
         count_ff <= 6'd5;
         ratio_ff <= 7'd40;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         if (csr_write) begin
            if (csr_index == csr_index_vertex_count) count_ff <= csr_data[5:0];
            else ratio_ff <= csr_data;
         end
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; it_ff <= it_in;
      ox_ff <= ox_in; oy_ff <= oy_in; out_ff <= out_in;
      num_ff <= num_in; qh_ff <= qh_in; rl_ff <= rl_in;
      k_ff <= k_in;
      if (state_ff == ST_IDLE && req_valid) begin
         cx_ff  <= 25'(req_data.center_x);
         cy_ff  <= 25'(req_data.center_y);
         bx_ff  <= VW'(25'(req_data.point_y) - 25'(req_data.center_y)) <<< 8;
         by_ff  <= VW'(25'(req_data.center_x) - 25'(req_data.point_x)) <<< 8;
         tot_ff <= {n_eff, 1'b0};
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule
